// ===== src/ndq_pkg.sv =====
`default_nettype none

package ndq_pkg;

  // Fixed widths of the stream fields and configuration registers.
  localparam int unsigned PixW    = 8;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned InvW    = 24;
  localparam int unsigned ZpW     = 9;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CntW    = 12;
  localparam int unsigned SrcMax  = 4096;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  // Default parameter values.
  localparam int unsigned DefOutWidth  = 128;
  localparam int unsigned DefOutHeight = 128;
  localparam int unsigned DefChannels  = 3;

  // Register reset values.
  localparam logic [SizeW-1:0] RstSrcWidth  = 13'd640;
  localparam logic [SizeW-1:0] RstSrcHeight = 13'd480;
  localparam logic [InvW-1:0]  RstInvScale  = 24'd65536;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_INV_SCALE   = 3'd2,
    REG_Q_OFFSET    = 3'd3,
    REG_SIGNED_MODE = 3'd4
  } ndq_reg_e;

  // Output grid position that travels alongside the pixel data.
  typedef struct packed {
    logic            last;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } ndq_pos_t;

endpackage

`default_nettype wire

// ===== src/ndq_sampler.sv =====
`default_nettype none

module ndq_sampler
  import ndq_pkg::*;
#(
  parameter int unsigned OUT_WIDTH  = DefOutWidth,
  parameter int unsigned OUT_HEIGHT = DefOutHeight
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             frame_start_i,
  input  wire logic [SizeW-1:0] src_width_i,
  input  wire logic [SizeW-1:0] src_height_i,
  output logic                  hit_o,
  output ndq_pos_t              pos_o
);

  localparam int unsigned OcW   = $clog2(OUT_WIDTH + 1);
  localparam int unsigned OrW   = $clog2(OUT_HEIGHT + 1);
  localparam int unsigned CaccW = $clog2(SrcMax * OUT_WIDTH + 1);
  localparam int unsigned RaccW = $clog2(SrcMax * OUT_HEIGHT + 1);

  logic [CntW-1:0]  col_q, col_d, row_q, row_d;
  logic [OcW-1:0]   ocol_q, ocol_d;
  logic [OrW-1:0]   orow_q, orow_d;
  // Source position scaled by the output size, so that a target compare
  // needs no division: col == floor(acc/OW) iff col*OW <= acc < col*OW+OW.
  logic [CaccW-1:0] csc_q, csc_d, cacc_q, cacc_d;
  logic [RaccW-1:0] rsc_q, rsc_d, racc_q, racc_d;

  logic [CntW-1:0]  col, row;
  logic [OcW-1:0]   ocol;
  logic [OrW-1:0]   orow;
  logic [CaccW-1:0] csc, cacc;
  logic [RaccW-1:0] rsc, racc;
  logic [SizeW-1:0] w, h;
  logic [CaccW:0]   csc_top;
  logic [RaccW:0]   rsc_top;
  logic             col_match, row_match, row_reached, row_end, grid_open;

  always_comb begin
    if (src_width_i < SizeW'(OUT_WIDTH)) begin
      w = SizeW'(OUT_WIDTH);
    end else if (src_width_i > SizeW'(SrcMax)) begin
      w = SizeW'(SrcMax);
    end else begin
      w = src_width_i;
    end
    if (src_height_i < SizeW'(OUT_HEIGHT)) begin
      h = SizeW'(OUT_HEIGHT);
    end else if (src_height_i > SizeW'(SrcMax)) begin
      h = SizeW'(SrcMax);
    end else begin
      h = src_height_i;
    end
  end

  always_comb begin
    // A frame start clears every counter before this pixel is looked at.
    col  = frame_start_i ? '0 : col_q;
    row  = frame_start_i ? '0 : row_q;
    ocol = frame_start_i ? '0 : ocol_q;
    orow = frame_start_i ? '0 : orow_q;
    csc  = frame_start_i ? '0 : csc_q;
    rsc  = frame_start_i ? '0 : rsc_q;
    cacc = frame_start_i ? '0 : cacc_q;
    racc = frame_start_i ? '0 : racc_q;

    csc_top     = {1'b0, csc} + (CaccW + 1)'(OUT_WIDTH);
    rsc_top     = {1'b0, rsc} + (RaccW + 1)'(OUT_HEIGHT);
    col_match   = (cacc >= csc) && ({1'b0, cacc} < csc_top);
    row_reached = {1'b0, racc} < rsc_top;
    row_match   = (racc >= rsc) && row_reached;
    grid_open   = orow < OrW'(OUT_HEIGHT);
    hit_o       = grid_open && (ocol < OcW'(OUT_WIDTH)) && row_match && col_match;
    row_end     = {1'b0, col} >= (w - SizeW'(1));

    pos_o.col  = PosW'(ocol);
    pos_o.row  = PosW'(orow);
    pos_o.last = (ocol == OcW'(OUT_WIDTH - 1)) && (orow == OrW'(OUT_HEIGHT - 1));

    col_d  = col;
    row_d  = row;
    csc_d  = csc;
    rsc_d  = rsc;
    orow_d = orow;
    racc_d = racc;
    ocol_d = hit_o ? ocol + OcW'(1) : ocol;
    cacc_d = hit_o ? cacc + CaccW'(w) : cacc;

    if (row_end) begin
      col_d  = '0;
      csc_d  = '0;
      ocol_d = '0;
      cacc_d = '0;
      if (grid_open && row_reached) begin
        orow_d = orow + OrW'(1);
        racc_d = racc + RaccW'(h);
      end
      if (row != {CntW{1'b1}}) begin
        row_d = row + CntW'(1);
        rsc_d = rsc + RaccW'(OUT_HEIGHT);
      end
    end else begin
      col_d = col + CntW'(1);
      csc_d = csc + CaccW'(OUT_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      csc_q  <= '0;
      rsc_q  <= '0;
      cacc_q <= '0;
      racc_q <= '0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      csc_q  <= csc_d;
      rsc_q  <= rsc_d;
      cacc_q <= cacc_d;
      racc_q <= racc_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ndq_lane.sv =====
`default_nettype none

module ndq_lane
  import ndq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  mul_en_i,
  input  wire logic                  out_en_i,
  input  wire logic [PixW-1:0]       pix_i,
  input  wire logic [InvW-1:0]       inv_scale_i,
  input  wire logic signed [ZpW-1:0] q_offset_i,
  input  wire logic                  signed_mode_i,
  output logic [PixW-1:0]            q_o
);

  localparam int unsigned ProdW = PixW + InvW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned ValW  = SumW - 16;

  logic [ProdW-1:0]       prod_q;
  logic [PixW-1:0]        q_q;
  logic signed [SumW-1:0] sum;
  logic signed [ValW-1:0] val, lo, hi;
  logic [PixW-1:0]        q_d;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= pix_i * inv_scale_i;
    end
  end

  always_comb begin
    // Q.16 value plus one half, then truncation toward zero.
    sum = $signed({2'b00, prod_q})
        + ($signed(SumW'(q_offset_i)) <<< 16)
        + $signed(SumW'(32768));
    val = sum[SumW-1:16];
    if (sum[SumW-1] && (sum[15:0] != 16'd0)) begin
      val = val + ValW'(1);
    end
    lo = signed_mode_i ? -ValW'(128) : ValW'(0);
    hi = signed_mode_i ? ValW'(127) : ValW'(255);
    if (val < lo) begin
      q_d = PixW'(lo);
    end else if (val > hi) begin
      q_d = PixW'(hi);
    end else begin
      q_d = PixW'(val);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ===== src/nearest_downscale_quantize.sv =====
// Nearest-neighbor downscaler with affine quantization.
//
// The slave stream takes one RGB888 source pixel per beat in raster order;
// tuser marks the first pixel of a frame and clears the position counters.
// Each pixel whose position hits the next point of the OUT_WIDTH x OUT_HEIGHT
// output grid leaves on the master stream as quantized bytes together with
// its output column and row; tlast flags the final grid point of the frame.
// Other pixels are consumed and produce nothing.
// The config channel writes src_width, src_height, inv_scale, q_offset and
// signed_mode by index; it is always ready and should only be used while no
// beat is in flight.
// A kept pixel enters the multiplier register at its accepting edge and the
// output register, which raises tvalid, once that is empty or the receiver takes
// its beat. Throughput is one pixel per cycle while the receiver does not stall,
// set by one multiplier lane per channel working side by side.
// When the receiver stalls, the output register holds and the multiplier
// stage may still take one more kept pixel; after that tready drops.
// Reset clears all counters and the pipeline, and loads the register
// defaults (640, 480, 1.0 in Q8.16, zero, unsigned).
`default_nettype none

module nearest_downscale_quantize
  import ndq_pkg::*;
#(
  parameter int unsigned OUT_WIDTH  = DefOutWidth,
  parameter int unsigned OUT_HEIGHT = DefOutHeight,
  parameter int unsigned CHANNELS   = DefChannels
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Source pixels.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [23:0]         s_axis_tdata_i,   // red, green, blue
  input  wire logic                s_axis_tuser_i,   // frame_start
  // Quantized output pixels.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [39:0]              m_axis_tdata_o,   // q_red, q_green, q_blue,
                                                     // out_col, out_row, zero pad
  output logic                     m_axis_tlast_o,   // frame_last
  // Register writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NumIn = 3;

  logic [SizeW-1:0]     src_width_q, src_height_q;
  logic [InvW-1:0]      inv_scale_q;
  logic signed [ZpW-1:0] q_offset_q;
  logic                 signed_mode_q;

  logic                 in_accept, hit, load1, move12;
  logic                 s1_valid_q, s2_valid_q;
  ndq_pos_t             pos, pos1_q, pos2_q;
  logic [PixW-1:0]      q [NumIn];

  // Registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= RstSrcWidth;
      src_height_q  <= RstSrcHeight;
      inv_scale_q   <= RstInvScale;
      q_offset_q    <= '0;
      signed_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ndq_reg_e'(cfg_addr_i))
        REG_SRC_WIDTH:   src_width_q   <= cfg_data_i[SizeW-1:0];
        REG_SRC_HEIGHT:  src_height_q  <= cfg_data_i[SizeW-1:0];
        REG_INV_SCALE:   inv_scale_q   <= cfg_data_i[InvW-1:0];
        REG_Q_OFFSET:    q_offset_q    <= $signed(cfg_data_i[ZpW-1:0]);
        REG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: stage one holds the products, stage two is the
  // output register. Non-kept pixels only advance the counters.
  assign move12          = s1_valid_q && (!s2_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || move12;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign load1           = in_accept && hit;

  ndq_sampler #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_sampler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_accept),
    .frame_start_i (s_axis_tuser_i),
    .src_width_i   (src_width_q),
    .src_height_i  (src_height_q),
    .hit_o         (hit),
    .pos_o         (pos)
  );

  // One quantizer lane per channel; channels that are not built read zero.
  for (genvar c = 0; c < NumIn; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      ndq_lane u_lane (
        .clk_i         (clk_i),
        .mul_en_i      (load1),
        .out_en_i      (move12),
        .pix_i         (s_axis_tdata_i[c*PixW +: PixW]),
        .inv_scale_i   (inv_scale_q),
        .q_offset_i    (q_offset_q),
        .signed_mode_i (signed_mode_q),
        .q_o           (q[c])
      );
    end else begin : g_off
      assign q[c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (load1) begin
        s1_valid_q <= 1'b1;
      end else if (move12) begin
        s1_valid_q <= 1'b0;
      end
      if (move12) begin
        s2_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      pos1_q <= pos;
    end
    if (move12) begin
      pos2_q <= pos1_q;
    end
  end

  // Merge the lane results and the grid position into one output beat.
  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tlast_o  = pos2_q.last;
  assign m_axis_tdata_o  = {2'b00, pos2_q.row, pos2_q.col, q[2], q[1], q[0]};

`ifndef ASSERT_OFF
  // The first pixel of a frame always sits on output point (0,0).
  a_frame_start_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tuser_i |-> hit)
    else $error("frame start pixel not kept");

  // With both stages full and the receiver stalled, no new pixel may enter.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while pipeline is full");

  // A kept pixel that is taken in while no stage stalls is held in stage one.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load1 && (!s1_valid_q || move12) && (!s2_valid_q || m_axis_tready_i)
      |=> s1_valid_q)
    else $error("kept pixel lost in stage one");

  // The last grid point sits in the final output column.
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> pos2_q.col == PosW'(OUT_WIDTH - 1))
    else $error("frame_last on wrong column");
`endif

endmodule

`default_nettype wire

// ===== test/nearest_downscale_quantize_tb.sv =====
`timescale 1ns / 100ps

module nearest_downscale_quantize_tb;
  import ndq_pkg::*;

  // Source beats from the back-pressure stretch on; the directed checks
  // before it add only a handful.
  localparam int unsigned RandomItems = 1940;
  // Cycles allowed after the last expected output before touching registers.
  // The block holds a pixel in its multiplier and output registers, so this covers
  // beats that are still in flight and produce nothing.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ResetCycles = 11;

  // One output pixel of the resized grid, as it is predicted.
  typedef struct packed {
    logic [PixW-1:0] q_red;
    logic [PixW-1:0] q_green;
    logic [PixW-1:0] q_blue;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            last;
  } grid_px_t;

  // Tracks the source position and the next grid point the same way the block
  // does, and keeps the grid pixels that are due on the output stream.
  class downscale_scoreboard;
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    logic [InvW-1:0]  inv_reg;
    logic [ZpW-1:0]   zp_reg;
    logic             signed_reg;
    int unsigned      src_col, src_row, grid_col, grid_row, col_acc, row_acc;
    grid_px_t         grid_pixels_due[$];
    int unsigned      errors;

    function new();
      width_reg  = RstSrcWidth;
      height_reg = RstSrcHeight;
      inv_reg    = RstInvScale;
      zp_reg     = '0;
      signed_reg = 1'b0;
      errors     = 0;
      clear_position();
    endfunction

    function void clear_position();
      src_col  = 0;
      src_row  = 0;
      grid_col = 0;
      grid_row = 0;
      col_acc  = 0;
      row_acc  = 0;
    endfunction

    function void write_reg(ndq_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_SRC_WIDTH:   width_reg  = value[SizeW-1:0];
        REG_SRC_HEIGHT:  height_reg = value[SizeW-1:0];
        REG_INV_SCALE:   inv_reg    = value[InvW-1:0];
        REG_Q_OFFSET:    zp_reg     = value[ZpW-1:0];
        REG_SIGNED_MODE: signed_reg = value[0];
        default: ;
      endcase
    endfunction

    // Sizes saturate at the output size below and at the counter range above.
    function int unsigned eff_size(logic [SizeW-1:0] value, int unsigned min_sz);
      if (value < min_sz) return min_sz;
      if (value > SrcMax) return SrcMax;
      return value;
    endfunction

    // Fixed-point affine quantization: add one half, then truncate toward zero.
    function logic [PixW-1:0] quant_byte(logic [PixW-1:0] pix);
      longint t, v, lo, hi;
      t = longint'(pix) * longint'(inv_reg) + longint'($signed(zp_reg)) * 65536 + 32768;
      v = t / 65536;
      lo = signed_reg ? -128 : 0;
      hi = signed_reg ? 127 : 255;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v[PixW-1:0];
    endfunction

    function void note_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b,
                             logic frame_start);
      int unsigned w, h, row_tgt, col_tgt;
      grid_px_t px;
      w = eff_size(width_reg, DefOutWidth);
      h = eff_size(height_reg, DefOutHeight);
      if (frame_start) clear_position();
      row_tgt = row_acc / DefOutHeight;
      col_tgt = col_acc / DefOutWidth;
      if (grid_row < DefOutHeight && grid_col < DefOutWidth &&
          src_row == row_tgt && src_col == col_tgt) begin
        px.q_red   = quant_byte(r);
        px.q_green = quant_byte(g);
        px.q_blue  = quant_byte(b);
        px.col     = grid_col[PosW-1:0];
        px.row     = grid_row[PosW-1:0];
        px.last    = (grid_col == DefOutWidth - 1) && (grid_row == DefOutHeight - 1);
        grid_pixels_due.push_back(px);
        grid_col++;
        col_acc += w;
      end
      // A row ends at the last source column; a shrunken width ends it at once.
      if (src_col >= w - 1) begin
        src_col  = 0;
        grid_col = 0;
        col_acc  = 0;
        if (grid_row < DefOutHeight && src_row >= row_tgt) begin
          grid_row++;
          row_acc += h;
        end
        if (src_row < SrcMax - 1) src_row++;
      end else begin
        src_col++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, int unsigned got, int unsigned want, grid_px_t due);
      if (got != want)
        report($sformatf("%s is %0d, expected %0d (grid col %0d, row %0d)",
                         name, got, want, due.col, due.row));
    endtask

    task check_beat(logic [39:0] data, logic last);
      grid_px_t due;
      if (grid_pixels_due.size() == 0) begin
        report($sformatf("output beat %h with no pixel due", data));
        return;
      end
      due = grid_pixels_due.pop_front();
      cmp_field("q_red",      data[7:0],   due.q_red,   due);
      cmp_field("q_green",    data[15:8],  due.q_green, due);
      cmp_field("q_blue",     data[23:16], due.q_blue,  due);
      cmp_field("out_col",    data[30:24], due.col,     due);
      cmp_field("out_row",    data[37:31], due.row,     due);
      cmp_field("frame_last", last,        due.last,    due);
    endtask
  endclass

  // Every input is known from time zero.
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [23:0]        s_tdata   = '0;
  logic               s_tuser   = 1'b0;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [39:0]        m_tdata;
  logic               m_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  downscale_scoreboard sb = new();

  // Chances in percent that the sender idles after a beat and that the
  // receiver stalls in a cycle, and a forced receiver hold-off in cycles.
  int unsigned src_idle_pct = 0;
  int unsigned stall_pct    = 0;
  int          hold_cycles  = 0;
  int unsigned sent_items   = 0;

  always #6 clk = ~clk;

  nearest_downscale_quantize dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  // Receiver: a pending hold-off wins over the random stall.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted output beat is compared with the oldest pixel due.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
  end

  // Offers one source pixel, waits for the handshake, then idles at random.
  task automatic send_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b,
                            logic frame_start);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    s_tuser  <= frame_start;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(r, g, b, frame_start);
    sent_items++;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // A random source pixel, with or without a frame start.
  task automatic send_random(logic frame_start);
    send_pixel(PixW'($urandom_range(255)), PixW'($urandom_range(255)),
               PixW'($urandom_range(255)), frame_start);
  endtask

  task automatic cfg_write(ndq_reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops the source, lets every due pixel come out and the pipeline empty.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.grid_pixels_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Registers are only rewritten once the block is idle.
  task automatic config_all(logic [SizeW-1:0] w, logic [SizeW-1:0] h, logic [InvW-1:0] inv,
                            logic [ZpW-1:0] zp, logic sm);
    settle();
    cfg_write(REG_SRC_WIDTH, w);
    cfg_write(REG_SRC_HEIGHT, h);
    cfg_write(REG_INV_SCALE, inv);
    cfg_write(REG_Q_OFFSET, zp);
    cfg_write(REG_SIGNED_MODE, sm);
  endtask

  function automatic void random_quant(output logic [InvW-1:0] inv, output logic [ZpW-1:0] zp,
                                       output logic sm);
    case ($urandom_range(9))
      0:       inv = '0;
      1:       inv = '1;
      2, 3:    inv = InvW'($urandom());
      default: inv = InvW'($urandom_range(24'h030000, 24'h004000));
    endcase
    zp = ZpW'($urandom_range(511));
    sm = 1'($urandom_range(1));
  endfunction

  // One stretch of source pixels under fresh settings. Most stretches open a
  // new frame; the rest carry on the current frame with changed sizes, and a
  // stray frame start now and then breaks a frame in the middle.
  task automatic run_segment(int unsigned base);
    logic [SizeW-1:0] w, h;
    logic [InvW-1:0]  inv;
    logic [ZpW-1:0]   zp;
    logic             sm, first_fs;
    int unsigned      row_len, npix;
    case ($urandom_range(9))
      0:       w = SizeW'($urandom_range(127, 0));
      1:       w = SizeW'($urandom_range(8191, 4096));
      2:       w = SizeW'($urandom_range(1000, 161));
      default: w = SizeW'($urandom_range(160, 128));
    endcase
    case ($urandom_range(9))
      0:       h = SizeW'($urandom_range(127, 0));
      1:       h = SizeW'($urandom_range(8191, 4096));
      2:       h = SizeW'($urandom_range(640, 161));
      default: h = SizeW'($urandom_range(160, 128));
    endcase
    random_quant(inv, zp, sm);
    config_all(w, h, inv, zp, sm);
    // Narrow frames run one to three whole rows and part of the next; wider ones 100 to 600 pixels.
    row_len = (w < DefOutWidth) ? DefOutWidth : w;
    if (row_len > 300) npix = $urandom_range(600, 100);
    else npix = row_len * $urandom_range(3, 1) + $urandom_range(row_len / 2, 0);
    // The last stretch stops at the item budget.
    if (npix > RandomItems - (sent_items - base)) npix = RandomItems - (sent_items - base);
    first_fs = ($urandom_range(99) < 85);
    for (int i = 0; i < npix; i++) begin
      // Idling phases: none, sender idle, receiver stalling, then both.
      case ((sent_items - base) * 4 / RandomItems)
        0: begin
          src_idle_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          src_idle_pct = 81;
          stall_pct    = 0;
        end
        2: begin
          src_idle_pct = 0;
          stall_pct    = 81;
        end
        default: begin
          src_idle_pct = 11;
          stall_pct    = 11;
        end
      endcase
      send_random((i == 0) ? first_fs : ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    logic [InvW-1:0] inv;
    logic [ZpW-1:0]  zp;
    logic            sm;
    int unsigned     base;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults after reset: the first pixel is grid point (0,0) with
    // no frame start, the next one is skipped because the width is 640.
    send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);

    // A width below the grid saturates to 128, a height above 4096 to 4096.
    config_all(13'd0, 13'd8191, 24'h010000, 9'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    // Offset -128 in signed mode: pixel 255 lands on 127, pixel 0 on -128.
    config_all(13'd128, 13'd128, 24'h010000, 9'h180, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
    send_pixel(8'd127, 8'd128, 8'd1, 1'b0);

    // A zero scale reduces every channel to the clamped offset.
    config_all(13'd128, 13'd128, 24'h000000, 9'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd77, 1'b0);
    config_all(13'd128, 13'd128, 24'h000000, 9'h100, 1'b1);
    send_pixel(8'd200, 8'd13, 8'd255, 1'b0);

    // Largest scale saturates nonzero pixels high in both clamp ranges.
    config_all(13'd128, 13'd128, 24'hFFFFFF, 9'd0, 1'b0);
    send_pixel(8'd255, 8'd1, 8'd0, 1'b0);
    config_all(13'd128, 13'd128, 24'hFFFFFF, 9'd255, 1'b1);
    send_pixel(8'd255, 8'd1, 8'd0, 1'b0);

    // Half scale with offset -1: a result of -0.5 truncates toward zero,
    // so a zero pixel gives 0 and not -1.
    config_all(13'd128, 13'd128, 24'h008000, 9'h1FF, 1'b1);
    send_pixel(8'd0, 8'd1, 8'd2, 1'b0);
    send_pixel(8'd3, 8'd255, 8'd254, 1'b0);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering pixels that are all kept, so the block fills up
    // and has to drop its input ready.
    base = sent_items;
    random_quant(inv, zp, sm);
    config_all(13'd128, 13'd128, inv, zp, sm);
    hold_cycles = 150;
    for (int i = 0; i < 80; i++)
      send_random(i == 0);

    while (sent_items - base < RandomItems) run_segment(base);

    settle();
    if (sb.grid_pixels_due.size() != 0)
      sb.report($sformatf("%0d pixels never came out", sb.grid_pixels_due.size()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: well over ten times the slowest correct run.
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ndq_pkg.sv
src/ndq_sampler.sv
src/ndq_lane.sv
src/nearest_downscale_quantize.sv
test/nearest_downscale_quantize_tb.sv
